>>> rtl/core/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Shared constants, codes and types for the positional list block.
// ----------------------------------------------------------------------------
package pli_pkg;

    localparam int CAPACITY = 8;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int POS_W    = 8;
    localparam int CMD_W    = 2;
    localparam int STAT_W   = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_FIND   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_ILLEGAL  = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CMP,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_DONE
    } t_state;

    // one write port, one read port
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } t_mem_req;

endpackage

>>> rtl/core/pli_mem.sv
// ----------------------------------------------------------------------------
// pli_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pli_mem import pli_pkg::*; (
    input  logic              i_clk,
    input  t_mem_req          i_req,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/positional_list_insert_delete_find.sv
// ----------------------------------------------------------------------------
// positional_list_insert_delete_find
// Ordered list of signed 32-bit entries with find, insert and delete.
// ----------------------------------------------------------------------------
// Sequencing: a rejected or no-op request goes straight to the done state;
//   find reads and compares one entry at a time, and insert and delete move
//   one entry at a time through a read state and a write state, as the entry
//   store's read data is registered. The done state holds until the result slot is free.
// Throughput: one request at a time; a new one is taken while a result waits.
// Reset (sync, active low) empties the list; entry contents are not cleared.
module positional_list_insert_delete_find import pli_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [CMD_W-1:0]         i_command,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [POS_W-1:0]         i_position,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [STAT_W-1:0]        o_status,
    output logic [POS_W-1:0]         o_found_position,
    output logic [POS_W-1:0]         o_length
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [IDX_W-1:0]  r_pos, n_pos;
    logic [DATA_W-1:0] r_val, n_val;
    t_status           r_status, n_status;
    logic [POS_W-1:0]  r_found, n_found;

    logic              r_out_valid;
    t_status           r_out_status;
    logic [POS_W-1:0]  r_out_found;
    logic [POS_W-1:0]  r_out_len;

    t_mem_req          mem_req;
    logic [DATA_W-1:0] mem_rdata;

    logic              accept;
    logic              slot_free;
    logic              cmp_hit;
    logic [CNT_W-1:0]  idx_inc;
    logic [POS_W-1:0]  count_ext;
    logic              is_full;

    assign accept    = i_valid && o_ready;
    assign slot_free = !r_out_valid || i_ready;
    assign cmp_hit   = (mem_rdata == r_val);
    assign idx_inc   = CNT_W'(r_idx) + CNT_W'(1);
    assign count_ext = POS_W'(r_count);
    assign is_full   = (r_count >= CNT_W'(CAPACITY));

    pli_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (t_cmd'(i_command))
                        CMD_FIND:   n_state = (r_count == '0) ? S_DONE : S_FIND_RD;
                        CMD_INSERT: n_state = (is_full || i_position > count_ext) ?
                                              S_DONE : S_INS_RD;
                        CMD_DELETE: n_state = (i_position >= count_ext) ?
                                              S_DONE : S_DEL_RD;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_FIND_RD:  n_state = S_FIND_CMP;
            S_FIND_CMP: n_state = (cmp_hit || idx_inc >= r_count) ? S_DONE : S_FIND_RD;
            S_INS_RD:   n_state = (r_idx == r_pos) ? S_DONE : S_INS_WR;
            S_INS_WR:   n_state = S_INS_RD;
            S_DEL_RD:   n_state = (idx_inc >= r_count) ? S_DONE : S_DEL_WR;
            S_DEL_WR:   n_state = S_DEL_RD;
            S_DONE:     n_state = slot_free ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_ready       = (r_state == S_IDLE);
        n_count       = r_count;
        n_idx         = r_idx;
        n_pos         = r_pos;
        n_val         = r_val;
        n_status      = r_status;
        n_found       = r_found;
        mem_req.we    = 1'b0;
        mem_req.waddr = r_idx;
        mem_req.wdata = mem_rdata;
        mem_req.raddr = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_val    = i_value;
                    n_pos    = i_position[IDX_W-1:0];
                    n_found  = '0;
                    n_status = ST_OK;
                    unique case (t_cmd'(i_command))
                        CMD_FIND: begin
                            n_idx = '0;
                            if (r_count == '0) begin
                                n_status = ST_NOTFOUND;
                            end
                        end
                        CMD_INSERT: begin
                            // fullness takes priority over a bad position
                            n_idx = r_count[IDX_W-1:0];
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else if (i_position > count_ext) begin
                                n_status = ST_ILLEGAL;
                            end
                        end
                        CMD_DELETE: begin
                            n_idx = i_position[IDX_W-1:0];
                            if (i_position >= count_ext) begin
                                n_status = ST_EMPTY;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_FIND_RD: ;
            S_FIND_CMP: begin
                if (cmp_hit) begin
                    n_found = POS_W'(r_idx);
                end else if (idx_inc >= r_count) begin
                    n_status = ST_NOTFOUND;
                end else begin
                    n_idx = idx_inc[IDX_W-1:0];
                end
            end
            S_INS_RD: begin
                if (r_idx == r_pos) begin
                    mem_req.we    = 1'b1;
                    mem_req.wdata = r_val;
                    n_count       = r_count + CNT_W'(1);
                end else begin
                    mem_req.raddr = r_idx - IDX_W'(1);
                end
            end
            S_INS_WR: begin
                // move entry idx-1 up to idx
                mem_req.we = 1'b1;
                n_idx      = r_idx - IDX_W'(1);
            end
            S_DEL_RD: begin
                if (idx_inc >= r_count) begin
                    n_count = r_count - CNT_W'(1);
                end else begin
                    mem_req.raddr = idx_inc[IDX_W-1:0];
                end
            end
            S_DEL_WR: begin
                // move entry idx+1 down to idx
                mem_req.we = 1'b1;
                n_idx      = idx_inc[IDX_W-1:0];
            end
            S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_status <= n_status;
        r_found  <= n_found;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && slot_free) begin
            r_out_status <= r_status;
            r_out_found  <= r_found;
            r_out_len    <= count_ext;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_found_position = r_out_found;
    assign o_length         = r_out_len;

    logic unused_accept;
    assign unused_accept = accept;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("list count above capacity");

    a_write_in_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.we |-> (r_state == S_INS_RD || r_state == S_INS_WR ||
                        r_state == S_DEL_WR))
        else $error("store written outside insert or delete");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_out_valid)) |-> $past(r_state == S_DONE))
        else $error("result loaded outside done state");

    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count)) |->
            $past(r_state == S_INS_RD || r_state == S_DEL_RD))
        else $error("count changed outside insert or delete");

    a_idle_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("request accepted without leaving idle");

endmodule

>>> tb/sv/pli_result_checker.sv
// ----------------------------------------------------------------------------
// pli_result_checker
// Tracks the positional list from the accepted requests, predicts the status,
// found position and length of each one, and compares them in order with the
// results the block hands out.
// ----------------------------------------------------------------------------
module pli_result_checker import pli_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_req_valid,
    input  logic                     i_req_ready,
    input  logic [CMD_W-1:0]         i_command,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [POS_W-1:0]         i_position,
    input  logic                     i_rsp_valid,
    input  logic                     i_rsp_ready,
    input  logic [STAT_W-1:0]        i_status,
    input  logic [POS_W-1:0]         i_found_position,
    input  logic [POS_W-1:0]         i_length,
    output int                       o_pending,
    output int                       o_mismatches
);

    typedef struct packed {
        t_status          status;
        logic [POS_W-1:0] found;
        logic [POS_W-1:0] length;
    } t_list_outcome;

    logic signed [DATA_W-1:0] list_mem [CAPACITY];
    int                       list_len;
    t_list_outcome            pending_outcomes [$];

    task automatic flag_mismatch(input string msg);
        $display("[%0d] mismatch: %s", $time, msg);
        o_mismatches++;
    endtask

    // Apply one request to the shadow list and return what the block should answer.
    function automatic t_list_outcome apply_list_op(input t_cmd cmd,
                                                    input logic signed [DATA_W-1:0] val,
                                                    input logic [POS_W-1:0] pos);
        t_list_outcome res;
        int            i;
        res.status = ST_OK;
        res.found  = '0;
        case (cmd)
            CMD_FIND: begin
                res.status = ST_NOTFOUND;
                // scan downward so the lowest match wins
                for (i = list_len - 1; i >= 0; i--) begin
                    if (list_mem[IDX_W'(i)] == val) begin
                        res.status = ST_OK;
                        res.found  = POS_W'(i);
                    end
                end
            end
            CMD_INSERT: begin
                if (list_len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else if (int'(pos) > list_len) begin
                    res.status = ST_ILLEGAL;
                end else begin
                    for (i = list_len; i > int'(pos); i--)
                        list_mem[IDX_W'(i)] = list_mem[IDX_W'(i-1)];
                    list_mem[pos[IDX_W-1:0]] = val;
                    list_len++;
                end
            end
            CMD_DELETE: begin
                if (int'(pos) >= list_len) begin
                    res.status = ST_EMPTY;
                end else begin
                    for (i = int'(pos); i < list_len - 1; i++)
                        list_mem[IDX_W'(i)] = list_mem[IDX_W'(i+1)];
                    list_len--;
                end
            end
            default: ;
        endcase
        res.length = POS_W'(list_len);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_list_outcome exp_res;
        if (!i_rst_n) begin
            list_len = 0;
            pending_outcomes.delete();
        end else begin
            // a result leaving at this edge can only belong to an older request
            if (i_rsp_valid && i_rsp_ready) begin
                if (pending_outcomes.size() == 0) begin
                    flag_mismatch($sformatf("result with none expected: st=%0d fp=%0d len=%0d",
                                            i_status, i_found_position, i_length));
                end else begin
                    exp_res = pending_outcomes.pop_front();
                    if (i_status !== exp_res.status)
                        flag_mismatch($sformatf("status %0d, expected %0d",
                                                i_status, exp_res.status));
                    if (i_found_position !== exp_res.found)
                        flag_mismatch($sformatf("found_position %0d, expected %0d",
                                                i_found_position, exp_res.found));
                    if (i_length !== exp_res.length)
                        flag_mismatch($sformatf("length %0d, expected %0d",
                                                i_length, exp_res.length));
                end
            end
            if (i_req_valid && i_req_ready)
                pending_outcomes.push_back(apply_list_op(t_cmd'(i_command), i_value,
                                                         i_position));
        end
        o_pending = pending_outcomes.size();
    end

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the positional list with directed corner requests and then random
// fill and drain traffic under several sender and receiver idling patterns;
// a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench import pli_pkg::*; ();

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 2*CAPACITY + 8;

    logic                     clk;
    logic                     rst_n;
    logic                     req_valid;
    logic                     req_ready;
    logic [CMD_W-1:0]         req_command;
    logic signed [DATA_W-1:0] req_value;
    logic [POS_W-1:0]         req_position;
    logic                     rsp_valid;
    logic                     rsp_ready;
    logic [STAT_W-1:0]        rsp_status;
    logic [POS_W-1:0]         rsp_found_position;
    logic [POS_W-1:0]         rsp_length;

    int pending;
    int mismatches;
    int cycle_count;
    int idle_pct;
    int stall_pct;
    int fill_bias;

    logic signed [DATA_W-1:0] value_pool [8] = '{
        32'sd0, 32'sd1, -32'sd1, 32'sh7FFF_FFFF,
        32'sh8000_0000, 32'sd5, 32'sd100, 32'sh5555_AAAA
    };

    positional_list_insert_delete_find dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (req_valid),
        .o_ready          (req_ready),
        .i_command        (req_command),
        .i_value          (req_value),
        .i_position       (req_position),
        .o_valid          (rsp_valid),
        .i_ready          (rsp_ready),
        .o_status         (rsp_status),
        .o_found_position (rsp_found_position),
        .o_length         (rsp_length)
    );

    pli_result_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_req_valid      (req_valid),
        .i_req_ready      (req_ready),
        .i_command        (req_command),
        .i_value          (req_value),
        .i_position       (req_position),
        .i_rsp_valid      (rsp_valid),
        .i_rsp_ready      (rsp_ready),
        .i_status         (rsp_status),
        .i_found_position (rsp_found_position),
        .i_length         (rsp_length),
        .o_pending        (pending),
        .o_mismatches     (mismatches)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // receiver side: random backpressure per cycle
    initial begin
        rsp_ready = 1'b0;
        forever begin
            @(negedge clk);
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic send_request(input t_cmd cmd, input logic signed [DATA_W-1:0] val,
                                input logic [POS_W-1:0] pos);
        int gap;
        gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 12) : 0;
        @(negedge clk);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            @(negedge clk);
        end
        req_valid    <= 1'b1;
        req_command  <= cmd;
        req_value    <= val;
        req_position <= pos;
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic random_request();
        int                       roll;
        int                       ins_w;
        t_cmd                     cmd;
        logic signed [DATA_W-1:0] val;
        logic [POS_W-1:0]         pos;
        // alternate between filling and draining so full and empty lists recur
        ins_w = fill_bias ? 55 : 20;
        roll  = $urandom_range(0, 99);
        if (roll < ins_w)
            cmd = CMD_INSERT;
        else if (roll < 75)
            cmd = CMD_DELETE;
        else if (roll < 95)
            cmd = CMD_FIND;
        else
            cmd = CMD_NOP;
        if ($urandom_range(0, 99) < 30)
            val = $urandom;
        else
            val = value_pool[3'($urandom_range(0, 7))];
        if ($urandom_range(0, 99) < 85)
            pos = POS_W'($urandom_range(0, CAPACITY + 1));
        else
            pos = POS_W'($urandom_range(0, 255));
        send_request(cmd, val, pos);
    endtask

    initial begin
        int phase;
        int n;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req_command  = CMD_NOP;
        req_value    = '0;
        req_position = '0;
        idle_pct     = 0;
        stall_pct    = 0;
        fill_bias    = 1;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // corner cases on an empty list
        send_request(CMD_FIND,   32'sd0, 8'd0);
        send_request(CMD_DELETE, 32'sd0, 8'd0);
        send_request(CMD_INSERT, 32'sd5, 8'd1);
        send_request(CMD_NOP,    32'shFFFF_FFFF, 8'hFF);
        // build up, appending at the end and inserting in front and middle
        send_request(CMD_INSERT, 32'sh7FFF_FFFF, 8'd0);
        send_request(CMD_INSERT, 32'sh8000_0000, 8'd1);
        send_request(CMD_INSERT, -32'sd1, 8'd0);
        send_request(CMD_INSERT, -32'sd1, 8'd3);
        send_request(CMD_FIND,   -32'sd1, 8'd0);
        send_request(CMD_FIND,   32'sh8000_0000, 8'd0);
        send_request(CMD_INSERT, 32'sd42, 8'd2);
        send_request(CMD_INSERT, 32'sd1, 8'd5);
        send_request(CMD_INSERT, 32'sd2, 8'd6);
        send_request(CMD_INSERT, 32'sd3, 8'd7);
        // full list: full wins over a bad position
        send_request(CMD_INSERT, 32'sd9, 8'hFF);
        send_request(CMD_INSERT, 32'sd9, 8'd3);
        send_request(CMD_FIND,   32'sd3, 8'd0);
        send_request(CMD_DELETE, 32'sd0, 8'hFF);
        send_request(CMD_DELETE, 32'sd0, 8'd8);
        send_request(CMD_DELETE, 32'sd0, 8'd7);
        send_request(CMD_DELETE, 32'sd0, 8'd0);
        send_request(CMD_DELETE, 32'sd0, 8'd3);
        send_request(CMD_FIND,   32'sd12345, 8'd0);
        send_request(CMD_INSERT, 32'sd0, 8'd6);
        send_request(CMD_NOP,    32'sd0, 8'd0);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 62; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 62; end
                default: begin idle_pct = 31; stall_pct = 31; end
            endcase
            for (n = 0; n < 500; n++) begin
                if (n % 48 == 0)
                    fill_bias = !fill_bias;
                random_request();
            end
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        if (mismatches == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/pli_pkg.sv
rtl/core/pli_mem.sv
rtl/core/positional_list_insert_delete_find.sv
tb/sv/pli_result_checker.sv
tb/sv/testbench.sv
